[rtl/kms_pkg.sv]
`timescale 1ns / 1ps

package kms_pkg;

    // Default sizes, handed to the top level as parameter defaults
    localparam int WAYS_DEF        = 8;
    localparam int RECORD_BITS_DEF = 64;
    localparam int KEY_BITS_DEF    = 32;

    // Stream count after reset
    localparam logic [3:0] NUM_STREAMS_RST = 4'd8;

    // Input word kind codes
    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_END    = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [63:0] record;
    } t_in_word;

    typedef struct packed {
        logic [63:0] out_record;
        logic [2:0]  source_stream;
        logic        done_res;
        logic        error;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_CMP,
        S_MRG_CMP,
        S_PLACE,
        S_FETCH,
        S_EMIT
    } t_state;

endpackage

[rtl/kway_merge_sorted_heads_core.sv]
`timescale 1ns / 1ps

// K-way merge of sorted record streams. One head record per stream is kept
// in a slot memory ordered by key (top KEY_BITS of the record, unsigned).
// After a num_streams write or a finished merge the block loads: one word per
// stream, streams 0, 1, ... in turn; the last load word yields the smallest
// head. Each later word refills the stream named by the last source_stream
// (a record, or an end mark that retires it), and yields the next smallest
// head, or done_res once every stream has ended. An end mark while loading
// yields error and restarts the load. Each record is placed by a walk of
// key compares, at most WAYS - 1: one per slot shifted, plus the compare
// that stops the walk when it does not reach the end of the list. A
// stalled output delays a word that yields a result until the output
// register is free. The walk uses the single key comparator and the
// one-read, one-write slot memory, which move one slot per cycle. The
// input is stalled while a word is in work.
module kway_merge_sorted_heads_core
    import kms_pkg::*;
#(
    parameter int WAYS        = WAYS_DEF,
    parameter int RECORD_BITS = RECORD_BITS_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_word   i_in_word,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_word  o_out_word
);

    localparam int IDX_W = $clog2(WAYS);
    localparam int CNT_W = $clog2(WAYS + 1);
    localparam int CFG_W = (CNT_W > 4) ? CNT_W : 4;
    localparam int KW    = (KEY_BITS < RECORD_BITS) ? KEY_BITS : RECORD_BITS;
    localparam int ENT_W = RECORD_BITS + IDX_W;

    t_state r_state, n_state;

    logic [CNT_W-1:0]       r_nact;
    logic [CNT_W-1:0]       r_load_cnt, n_load_cnt;
    logic                   r_merging, n_merging;
    logic [CNT_W-1:0]       r_head, n_head;
    logic [IDX_W-1:0]       r_pos, n_pos;
    logic [RECORD_BITS-1:0] r_new_rec, n_new_rec;
    logic [IDX_W-1:0]       r_new_sid, n_new_sid;
    logic [IDX_W-1:0]       r_cur_sid, n_cur_sid;
    logic                   r_res_err, n_res_err;
    logic                   r_res_done, n_res_done;
    logic                   r_out_valid, n_out_valid;
    t_out_word              r_out_word, n_out_word;

    logic                   mem_we;
    logic [IDX_W-1:0]       mem_wr_addr;
    logic [ENT_W-1:0]       mem_wr_data;
    logic [IDX_W-1:0]       mem_rd_addr;
    logic [ENT_W-1:0]       mem_rd_data;

    logic                   in_fire;
    logic                   out_free;
    logic [RECORD_BITS-1:0] rd_rec;
    logic [IDX_W-1:0]       rd_sid;
    logic [KW-1:0]          new_key;
    logic [KW-1:0]          rd_key;
    logic                   new_lt;
    logic                   new_gt;
    logic                   load_wrap;
    logic [IDX_W-1:0]       load_pos;
    logic [CNT_W-1:0]       head_inc;
    logic [CNT_W-1:0]       pos_ext;
    logic [CNT_W-1:0]       cnt_inc;
    logic [CFG_W-1:0]       cfg_ext;
    logic [CNT_W-1:0]       cfg_nact;
    logic [IDX_W+2:0]       sid_ext;

    kms_slot_mem #(
        .DEPTH (WAYS),
        .WIDTH (ENT_W)
    ) u_slot_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // Handshake and shared comparator
    assign in_fire   = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign rd_rec    = mem_rd_data[ENT_W-1 -: RECORD_BITS];
    assign rd_sid    = mem_rd_data[IDX_W-1:0];
    assign new_key   = r_new_rec[RECORD_BITS-1 -: KW];
    assign rd_key    = rd_rec[RECORD_BITS-1 -: KW];
    assign new_lt    = new_key < rd_key;
    assign new_gt    = new_key > rd_key;
    assign load_wrap = r_load_cnt >= r_nact;
    assign load_pos  = load_wrap ? '0 : r_load_cnt[IDX_W-1:0];
    assign head_inc  = r_head + CNT_W'(1);
    assign pos_ext   = CNT_W'(r_pos);
    assign cnt_inc   = r_load_cnt + CNT_W'(1);
    assign sid_ext   = {3'b000, rd_sid};

    // Stream count clamp: 0 acts as 1, above WAYS acts as WAYS
    assign cfg_ext  = CFG_W'(i_cfg_data);
    assign cfg_nact = (cfg_ext == '0)          ? CNT_W'(1) :
                      (cfg_ext > CFG_W'(WAYS)) ? CNT_W'(WAYS) :
                                                 cfg_ext[CNT_W-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (!r_merging) begin
                        if (i_in_word.kind == KIND_END) begin
                            n_state = S_EMIT;
                        end else if (load_pos == '0) begin
                            n_state = S_PLACE;
                        end else begin
                            n_state = S_LOAD_CMP;
                        end
                    end else begin
                        if (i_in_word.kind == KIND_END) begin
                            n_state = (head_inc >= r_nact) ? S_EMIT : S_FETCH;
                        end else if (head_inc < r_nact) begin
                            n_state = S_MRG_CMP;
                        end else begin
                            n_state = S_PLACE;
                        end
                    end
                end
            end
            S_LOAD_CMP: begin
                if (!new_lt || r_pos == IDX_W'(1)) begin
                    n_state = S_PLACE;
                end
            end
            S_MRG_CMP: begin
                if (!new_gt || pos_ext + CNT_W'(2) >= r_nact) begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                if (!r_merging && cnt_inc < r_nact) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath, slot memory control and output register
    always_comb begin
        n_load_cnt  = r_load_cnt;
        n_merging   = r_merging;
        n_head      = r_head;
        n_pos       = r_pos;
        n_new_rec   = r_new_rec;
        n_new_sid   = r_new_sid;
        n_cur_sid   = r_cur_sid;
        n_res_err   = r_res_err;
        n_res_done  = r_res_done;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        mem_we      = 1'b0;
        mem_wr_addr = r_pos;
        mem_wr_data = {r_new_rec, r_new_sid};
        mem_rd_addr = r_head[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_new_rec = i_in_word.record[RECORD_BITS-1:0];
                    if (!r_merging) begin
                        if (i_in_word.kind == KIND_END) begin
                            // end mark while loading: error, restart load
                            n_res_err  = 1'b1;
                            n_load_cnt = '0;
                            n_head     = '0;
                        end else begin
                            // insert behind equal keys, walking downward
                            n_load_cnt  = CNT_W'(load_pos);
                            n_pos       = load_pos;
                            n_new_sid   = load_pos;
                            mem_rd_addr = load_pos - IDX_W'(1);
                        end
                    end else begin
                        if (i_in_word.kind == KIND_END) begin
                            // retire the head slot
                            if (head_inc >= r_nact) begin
                                n_res_done = 1'b1;
                                n_merging  = 1'b0;
                                n_load_cnt = '0;
                                n_head     = '0;
                            end else begin
                                n_head = head_inc;
                            end
                        end else begin
                            // refill head, insert ahead of equal keys upward
                            n_pos       = r_head[IDX_W-1:0];
                            n_new_sid   = r_cur_sid;
                            mem_rd_addr = head_inc[IDX_W-1:0];
                        end
                    end
                end
            end
            S_LOAD_CMP: begin
                if (new_lt) begin
                    mem_we      = 1'b1;
                    mem_wr_data = mem_rd_data;
                    n_pos       = r_pos - IDX_W'(1);
                    mem_rd_addr = r_pos - IDX_W'(2);
                end
            end
            S_MRG_CMP: begin
                if (new_gt) begin
                    mem_we      = 1'b1;
                    mem_wr_data = mem_rd_data;
                    n_pos       = r_pos + IDX_W'(1);
                    mem_rd_addr = r_pos + IDX_W'(2);
                end
            end
            S_PLACE: begin
                mem_we = 1'b1;
                if (!r_merging) begin
                    n_load_cnt = cnt_inc;
                    if (cnt_inc >= r_nact) begin
                        n_merging = 1'b1;
                        n_head    = '0;
                    end
                end
            end
            S_FETCH: begin
                // read of the head slot is issued by default
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_res_err   = 1'b0;
                    n_res_done  = 1'b0;
                    if (r_res_err || r_res_done) begin
                        n_out_word.out_record    = '0;
                        n_out_word.source_stream = '0;
                        n_out_word.done_res      = r_res_done;
                        n_out_word.error         = r_res_err;
                    end else begin
                        n_out_word.out_record    = 64'(rd_rec);
                        n_out_word.source_stream = sid_ext[2:0];
                        n_out_word.done_res      = 1'b0;
                        n_out_word.error         = 1'b0;
                        n_cur_sid                = rd_sid;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nact      <= (int'(NUM_STREAMS_RST) > WAYS) ? CNT_W'(WAYS)
                                                           : CNT_W'(NUM_STREAMS_RST);
            r_load_cnt  <= '0;
            r_merging   <= 1'b0;
            r_head      <= '0;
            r_res_err   <= 1'b0;
            r_res_done  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_err   <= n_res_err;
            r_res_done  <= n_res_done;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_nact     <= cfg_nact;
                r_load_cnt <= '0;
                r_merging  <= 1'b0;
                r_head     <= '0;
            end else begin
                r_load_cnt <= n_load_cnt;
                r_merging  <= n_merging;
                r_head     <= n_head;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_new_rec  <= n_new_rec;
        r_new_sid  <= n_new_sid;
        r_cur_sid  <= n_cur_sid;
        r_out_word <= n_out_word;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

[rtl/kms_slot_mem.sv]
`timescale 1ns / 1ps

module kms_slot_mem
    import kms_pkg::*;
#(
    parameter int DEPTH = WAYS_DEF,
    parameter int WIDTH = RECORD_BITS_DEF + $clog2(WAYS_DEF)
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
    import kms_pkg::*;

    localparam int WAYS        = WAYS_DEF;
    localparam int RECORD_BITS = RECORD_BITS_DEF;
    localparam int KEY_BITS    = KEY_BITS_DEF;
    localparam int ITEMS       = 450;
    localparam int DIR_ROWS    = 24;
    localparam int SETTLE      = 16;     // extra wait once no result is pending
    localparam int LONG_HOLD   = 300;
    localparam int IDLE_LIMIT  = 3000;

    localparam t_out_word W_ERR  = '{64'd0, 3'd0, 1'b0, 1'b1};
    localparam t_out_word W_DONE = '{64'd0, 3'd0, 1'b1, 1'b0};
    localparam t_out_word W_ZERO = '{64'd0, 3'd0, 1'b0, 1'b0};

    typedef struct packed {
        logic        do_cfg;
        logic [3:0]  cfg;
        logic        kind;
        logic [63:0] rec;
        logic        typed;
        t_out_word   want;
    } t_dir_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [3:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_word   i_in_word;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_word  o_out_word;

    // Side info that travels with the driven word
    logic       drv_typed;
    t_out_word  drv_want;

    // Model of the head list
    logic [63:0] slot_rec  [WAYS];
    logic [2:0]  slot_id   [WAYS];
    bit          slot_live [WAYS];
    int          fill_cnt;
    bit          merging;
    logic [3:0]  stream_cfg;

    t_out_word   merged_q [$];
    int          mismatch_cnt = 0;
    int          idle_cycles  = 0;
    int          words_sent   = 0;
    int          ways_now     = WAYS;
    bit          calm         = 1'b0;
    bit          hold_req     = 1'b0;

    t_dir_row dir_table [DIR_ROWS] = '{
        // end mark right after reset
        '{1'b0, 4'd0,  KIND_END,    64'd0,                   1'b1, W_ERR},
        // 15 clamps to eight streams; equal keys, key extremes
        '{1'b1, 4'd15, KIND_RECORD, 64'hFFFF_FFFF_0000_0000, 1'b0, W_ZERO},
        '{1'b0, 4'd0,  KIND_RECORD, 64'h0000_0000_FFFF_FFFF, 1'b0, W_ZERO},
        '{1'b0, 4'd0,  KIND_RECORD, 64'h0000_0007_0000_0001, 1'b0, W_ZERO},
        '{1'b0, 4'd0,  KIND_RECORD, 64'h0000_0007_0000_0002, 1'b0, W_ZERO},
        '{1'b0, 4'd0,  KIND_RECORD, 64'h0000_0000_0000_0000, 1'b0, W_ZERO},
        '{1'b0, 4'd0,  KIND_RECORD, 64'h0000_0007_0000_0003, 1'b0, W_ZERO},
        '{1'b0, 4'd0,  KIND_RECORD, 64'h8000_0000_0000_0000, 1'b0, W_ZERO},
        '{1'b0, 4'd0,  KIND_RECORD, 64'h0000_0007_0000_0004, 1'b0, W_ZERO},
        '{1'b0, 4'd0,  KIND_RECORD, 64'h0000_0007_0000_0005, 1'b0, W_ZERO},
        '{1'b0, 4'd0,  KIND_END,    64'h0000_0000_0000_0000, 1'b0, W_ZERO},
        // write in mid merge abandons it; then an early end mark
        '{1'b1, 4'd3,  KIND_END,    64'hDEAD_BEEF_DEAD_BEEF, 1'b1, W_ERR},
        '{1'b0, 4'd0,  KIND_RECORD, 64'h0000_0005_0000_000A, 1'b0, W_ZERO},
        '{1'b0, 4'd0,  KIND_RECORD, 64'h0000_0005_0000_000B, 1'b0, W_ZERO},
        '{1'b0, 4'd0,  KIND_RECORD, 64'h0000_0002_0000_000C, 1'b0, W_ZERO},
        '{1'b0, 4'd0,  KIND_RECORD, 64'h0000_0005_0000_000D, 1'b0, W_ZERO},
        '{1'b0, 4'd0,  KIND_END,    64'd0,                   1'b0, W_ZERO},
        '{1'b0, 4'd0,  KIND_END,    64'd0,                   1'b0, W_ZERO},
        '{1'b0, 4'd0,  KIND_END,    64'd0,                   1'b1, W_DONE},
        // single stream
        '{1'b1, 4'd1,  KIND_RECORD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
          '{64'hFFFF_FFFF_FFFF_FFFF, 3'd0, 1'b0, 1'b0}},
        '{1'b0, 4'd0,  KIND_RECORD, 64'd0,                   1'b1, W_ZERO},
        '{1'b0, 4'd0,  KIND_END,    64'd0,                   1'b1, W_DONE},
        // zero streams act as one
        '{1'b1, 4'd0,  KIND_RECORD, 64'h5,                   1'b1,
          '{64'h5, 3'd0, 1'b0, 1'b0}},
        '{1'b0, 4'd0,  KIND_END,    64'd0,                   1'b1, W_DONE}
    };

    kway_merge_sorted_heads_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always #4 i_clk = ~i_clk;

    function automatic int clamp_ways(input logic [3:0] v);
        int n;
        n = int'(v);
        if (n < 1) n = 1;
        if (n > WAYS) n = WAYS;
        return n;
    endfunction

    function automatic logic [KEY_BITS-1:0] key_of(input logic [63:0] r);
        return r[RECORD_BITS-1 -: KEY_BITS];
    endfunction

    function automatic void restart_load();
        for (int i = 0; i < WAYS; i++) slot_live[i] = 1'b0;
        fill_cnt = 0;
        merging  = 1'b0;
    endfunction

    function automatic void swap_slots(input int a, input int b);
        logic [63:0] r;
        logic [2:0]  s;
        bit          l;
        r = slot_rec[a];  s = slot_id[a];  l = slot_live[a];
        slot_rec[a]  = slot_rec[b];
        slot_id[a]   = slot_id[b];
        slot_live[a] = slot_live[b];
        slot_rec[b]  = r;  slot_id[b] = s;  slot_live[b] = l;
    endfunction

    function automatic int first_live(input int n);
        for (int i = 0; i < n; i++)
            if (slot_live[i]) return i;
        return -1;
    endfunction

    // One input word through the head list; returns 1 when a word comes out
    function automatic bit merge_heads(input logic kind, input logic [63:0] rec,
                                       output t_out_word res);
        int n;
        int j;
        int f;
        n   = clamp_ways(stream_cfg);
        res = '0;
        if (!merging) begin
            if (kind == KIND_END) begin
                restart_load();
                res.error = 1'b1;
                return 1'b1;
            end
            if (fill_cnt >= n) restart_load();
            j = fill_cnt;
            slot_rec[j]  = rec;
            slot_id[j]   = j[2:0];
            slot_live[j] = 1'b1;
            // land behind equal keys
            while (j > 0 && key_of(slot_rec[j]) < key_of(slot_rec[j-1])) begin
                swap_slots(j, j - 1);
                j--;
            end
            fill_cnt++;
            if (fill_cnt < n) return 1'b0;
            merging = 1'b1;
        end else begin
            f = first_live(n);
            if (f >= 0) begin
                j = f;
                if (kind == KIND_END) begin
                    slot_live[j] = 1'b0;
                end else begin
                    // refill lands ahead of equal keys
                    slot_rec[j] = rec;
                    while (j + 1 < n && key_of(slot_rec[j]) > key_of(slot_rec[j+1])) begin
                        swap_slots(j, j + 1);
                        j++;
                    end
                end
            end
        end
        f = first_live(n);
        if (f < 0) begin
            restart_load();
            res.done_res = 1'b1;
            return 1'b1;
        end
        res.out_record    = slot_rec[f];
        res.source_stream = slot_id[f];
        return 1'b1;
    endfunction

    function automatic logic [63:0] rand_record();
        logic [31:0] key;
        case ($urandom_range(0, 7))
            0: key = '0;
            1: key = '1;
            2, 3, 4: key = $urandom_range(0, 3);
            default: key = $urandom;
        endcase
        return {key, 32'($urandom)};
    endfunction

    // Offer one word and hold it until taken
    task automatic send_word(input logic kind, input logic [63:0] rec,
                             input logic typed, input t_out_word want);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_in_word.kind   <= kind;
        i_in_word.record <= rec;
        drv_typed        <= typed;
        drv_want         <= want;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        words_sent++;
    endtask

    // Stop sending and wait for every pending word plus the block's own latency
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (merged_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_streams(input logic [3:0] v);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        ways_now = clamp_ways(v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Load every stream, then refill until all have ended (or cut short)
    task automatic run_merge(input int n, input bit cut);
        int ends;
        int steps;
        int cut_at;
        ends   = 0;
        steps  = 0;
        cut_at = cut ? $urandom_range(0, 2 * n) : -1;
        for (int s = 0; s < n; s++) send_word(KIND_RECORD, rand_record(), 1'b0, '0);
        while (ends < n && steps != cut_at) begin
            if ($urandom_range(0, 9) < 3) begin
                send_word(KIND_END, rand_record(), 1'b0, '0);
                ends++;
            end else begin
                send_word(KIND_RECORD, rand_record(), 1'b0, '0);
            end
            steps++;
        end
    endtask

    // Predict on input acceptance, check on output acceptance
    always @(posedge i_clk) begin : monitor
        t_out_word pred;
        t_out_word want;
        bit        got;
        if (i_rst_n) begin
            idle_cycles++;
            if (i_cfg_we) begin
                idle_cycles = 0;
                stream_cfg  = i_cfg_data;
                restart_load();
            end
            if (i_in_valid && o_in_stall === 1'b0) begin
                idle_cycles = 0;
                got = merge_heads(i_in_word.kind, i_in_word.record, pred);
                if (drv_typed) merged_q.push_back(drv_want);
                else if (got) merged_q.push_back(pred);
            end
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                idle_cycles = 0;
                if (merged_q.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t unexpected word: rec=%h src=%0d done=%b err=%b", $time,
                             o_out_word.out_record, o_out_word.source_stream,
                             o_out_word.done_res, o_out_word.error);
                end else begin
                    want = merged_q.pop_front();
                    if (o_out_word.out_record !== want.out_record ||
                        o_out_word.source_stream !== want.source_stream ||
                        o_out_word.done_res !== want.done_res ||
                        o_out_word.error !== want.error) begin
                        mismatch_cnt++;
                        $display("%0t mismatch: expected rec=%h src=%0d done=%b err=%b",
                                 $time, want.out_record, want.source_stream,
                                 want.done_res, want.error);
                        $display("%0t            actual rec=%h src=%0d done=%b err=%b",
                                 $time, o_out_word.out_record, o_out_word.source_stream,
                                 o_out_word.done_res, o_out_word.error);
                    end
                end
            end
        end
    end

    // Output back-pressure: random bursts, one long hold on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
                i_out_stall <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Nothing accepted for too long
    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin
        int  kind_pick;
        bit  hold_done;
        bit  pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_word  = '0;
        drv_typed  = 1'b0;
        drv_want   = '0;
        for (int i = 0; i < WAYS; i++) begin
            slot_rec[i] = '0;
            slot_id[i]  = '0;
        end
        stream_cfg = NUM_STREAMS_RST;
        restart_load();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_table[r].do_cfg) write_streams(dir_table[r].cfg);
            send_word(dir_table[r].kind, dir_table[r].rec, dir_table[r].typed,
                      dir_table[r].want);
        end

        // random sessions: mostly full merges, some broken loads and cut merges
        while (words_sent < ITEMS) begin
            kind_pick = $urandom_range(0, 9);
            if ($urandom_range(0, 2) == 0) write_streams(4'($urandom_range(0, 15)));
            if (kind_pick == 0) begin
                repeat ($urandom_range(0, ways_now - 1))
                    send_word(KIND_RECORD, rand_record(), 1'b0, '0);
                send_word(KIND_END, rand_record(), 1'b0, '0);
            end else begin
                run_merge(ways_now, kind_pick == 1);
                if (kind_pick == 1) write_streams(4'($urandom_range(0, 15)));
            end
            if (!hold_done && words_sent > 150) begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
                // keep offering records while the output is held
                repeat (ways_now + 8) send_word(KIND_RECORD, rand_record(), 1'b0, '0);
            end
            if (!pause_done && words_sent > 300) begin
                pause_done = 1'b1;
                drain_results();
            end
            if (words_sent > ITEMS - 60) calm = 1'b1;
        end

        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/kms_pkg.sv
rtl/kms_slot_mem.sv
rtl/kway_merge_sorted_heads_core.sv
bench/tb.sv
